FILE: src/ebc_pkg.sv
package ebc_pkg;

  // widths fixed by the item and register formats
  localparam int COUNT_W = 8;
  localparam int TICK_W  = 16;

  // function codes of an input word
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // blink phase of the code under way
  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RDK  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // configuration register indexes
  localparam logic [1:0] REG_ON_TICKS    = 2'd0;
  localparam logic [1:0] REG_OFF_TICKS   = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS   = 2'd2;
  localparam logic [1:0] REG_COUNT_LIMIT = 2'd3;

  // register reset values
  localparam logic [TICK_W-1:0]  ON_TICKS_RST    = 16'd80;
  localparam logic [TICK_W-1:0]  OFF_TICKS_RST   = 16'd320;
  localparam logic [TICK_W-1:0]  GAP_TICKS_RST   = 16'd1200;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd255;

  // a zero duration acts as one tick
  function automatic logic [TICK_W-1:0] load_len(input logic [TICK_W-1:0] v);
    load_len = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

FILE: src/ebc_ram.sv
module ebc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ebc_store.sv
module ebc_store #(
  parameter int KIND_COUNT = 16,
  localparam int KW = $clog2(KIND_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [KW-1:0]              raddr,
  input  logic                       we,
  input  logic [KW-1:0]              waddr,
  input  logic [ebc_pkg::COUNT_W-1:0] wdata,
  output logic [ebc_pkg::COUNT_W-1:0] rdata
);

  logic [KIND_COUNT-1:0]       vld;
  logic                        rd_vld;
  logic                        rd_one;
  logic [ebc_pkg::COUNT_W-1:0] ram_q;

  ebc_ram #(
    .WIDTH(ebc_pkg::COUNT_W),
    .DEPTH(KIND_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // flag and reset value travel with the read data
  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    rd_one <= (raddr == KW'(1));
  end

  // unwritten entries read as reset value: heartbeat kind holds one
  assign rdata = rd_vld ? ram_q : ebc_pkg::COUNT_W'(rd_one);

endmodule

FILE: src/error_blink_code_sequencer.sv
// channel   | valid      | stall      | payload
// ----------+------------+------------+----------------------------------
// input     | in_valid   | in_stall   | func, error_kind
// output    | out_valid  | out_stall  | led_on, showing_kind, kind_count
// config    | cfg_wen    | (none)     | cfg_index, cfg_data
//
// set, clear and unused words go through S_RDK and S_EMIT to the result register,
// and the next word is taken once the sequencer is back in S_IDLE.
// a tick takes the same path, or goes through S_SCAN before the result register
// when it looks for the next kind with a nonzero counter: one counter memory
// read per cycle.
// reset: counters read as zero, heartbeat kind as one; no clearing pass.
// one word is worked on at a time; a new word is taken while the previous
// result still waits in the output register behind out_stall, and the word
// after that waits until the output register is free.
module error_blink_code_sequencer #(
  parameter int KIND_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  error_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        led_on,
  output logic [3:0]  showing_kind,
  output logic [7:0]  kind_count,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int KW = $clog2(KIND_COUNT);
  localparam int SW = (KW > 4) ? KW : 4;
  localparam int CW = ebc_pkg::COUNT_W;
  localparam int TW = ebc_pkg::TICK_W;

  ebc_pkg::state_t state, state_next;
  ebc_pkg::phase_t phase, phase_next;
  ebc_pkg::func_t  func_q;
  logic [3:0]      kind_q;

  logic [TW-1:0] on_ticks, off_ticks, gap_ticks;
  logic [CW-1:0] count_limit;

  logic [KW-1:0] current_kind, current_kind_next;
  logic [KW-1:0] flashes_done, flashes_done_next;
  logic [TW-1:0] ticks_left, ticks_left_next;
  logic          led_level, led_level_next;
  logic [CW-1:0] res_cnt, res_cnt_next;
  logic [KW-1:0] scan_k, scan_k_next;
  logic [KW-1:0] chk_k;
  logic          chk_v, chk_v_next;
  logic [KW-1:0] rem, rem_next;

  logic          accept;
  logic [SW-1:0] in_kind_ext, q_kind_ext, cur_ext;
  logic          kind_ok;
  logic [KW-1:0] raddr;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] cnt_inc;
  logic          st_we;
  logic [CW-1:0] st_wdata;
  logic [KW-1:0] start_k, step_k, flash_inc;
  logic [TW-1:0] on_len, off_len, gap_len;
  logic          emit_go;

  assign in_stall = (state != ebc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // kind number fitted to the memory address width
  assign in_kind_ext = SW'(error_kind);
  assign q_kind_ext  = SW'(kind_q);
  assign cur_ext     = SW'(current_kind);
  assign kind_ok     = (32'(kind_q) < 32'(KIND_COUNT));

  // read the addressed counter on accept, walk the kinds while scanning
  assign raddr = (state == ebc_pkg::S_IDLE) ? in_kind_ext[KW-1:0] : scan_k;

  // read-modify-write of the addressed counter; no word is accepted
  // until the write-back is done, so reads never overlap a pending write
  assign cnt_inc  = (rd_cnt < count_limit) ? rd_cnt + CW'(1) : rd_cnt;
  assign st_we    = (state == ebc_pkg::S_RDK) && kind_ok &&
                    (func_q == ebc_pkg::FUNC_SET || func_q == ebc_pkg::FUNC_CLEAR);
  assign st_wdata = (func_q == ebc_pkg::FUNC_SET) ? cnt_inc : '0;

  ebc_store #(
    .KIND_COUNT(KIND_COUNT)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .raddr(raddr),
    .we   (st_we),
    .waddr(q_kind_ext[KW-1:0]),
    .wdata(st_wdata),
    .rdata(rd_cnt)
  );

  // scan order wraps over kinds 1 .. KIND_COUNT-1
  assign start_k   = (current_kind == KW'(KIND_COUNT - 1)) ? KW'(1) : current_kind + KW'(1);
  assign step_k    = (scan_k == KW'(KIND_COUNT - 1)) ? KW'(1) : scan_k + KW'(1);
  assign flash_inc = flashes_done + KW'(1);
  assign on_len    = ebc_pkg::load_len(on_ticks);
  assign off_len   = ebc_pkg::load_len(off_ticks);
  assign gap_len   = ebc_pkg::load_len(gap_ticks);
  assign emit_go   = (state == ebc_pkg::S_EMIT) && (!out_valid || !out_stall);

  // sequencer next state
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    current_kind_next = current_kind;
    flashes_done_next = flashes_done;
    ticks_left_next   = ticks_left;
    led_level_next    = led_level;
    res_cnt_next      = res_cnt;
    scan_k_next       = step_k;
    chk_v_next        = 1'b1;
    rem_next          = rem;
    unique case (state)
      ebc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ebc_pkg::S_RDK;
        end
      end
      ebc_pkg::S_RDK: begin
        state_next = ebc_pkg::S_EMIT;
        if (!kind_ok) begin
          res_cnt_next = '0;
        end else if (func_q == ebc_pkg::FUNC_SET || func_q == ebc_pkg::FUNC_CLEAR) begin
          res_cnt_next = st_wdata;
        end else begin
          res_cnt_next = rd_cnt;
        end
        if (func_q == ebc_pkg::FUNC_TICK) begin
          scan_k_next = start_k;
          chk_v_next  = 1'b0;
          rem_next    = KW'(KIND_COUNT - 1);
          case (phase)
            ebc_pkg::PH_SCAN: begin
              state_next = ebc_pkg::S_SCAN;
            end
            ebc_pkg::PH_ON: begin
              led_level_next = 1'b1;
              if (ticks_left > TW'(1)) begin
                ticks_left_next = ticks_left - TW'(1);
              end else begin
                phase_next      = ebc_pkg::PH_OFF;
                ticks_left_next = off_len;
              end
            end
            ebc_pkg::PH_OFF: begin
              led_level_next = 1'b0;
              if (ticks_left > TW'(1)) begin
                ticks_left_next = ticks_left - TW'(1);
              end else begin
                flashes_done_next = flash_inc;
                if (flash_inc < current_kind) begin
                  phase_next      = ebc_pkg::PH_ON;
                  ticks_left_next = on_len;
                end else begin
                  phase_next      = ebc_pkg::PH_GAP;
                  ticks_left_next = gap_len;
                end
              end
            end
            default: begin
              led_level_next = 1'b0;
              if (ticks_left > TW'(1)) begin
                ticks_left_next = ticks_left - TW'(1);
              end else begin
                ticks_left_next = '0;
                state_next      = ebc_pkg::S_SCAN;
              end
            end
          endcase
        end
      end
      ebc_pkg::S_SCAN: begin
        if (chk_v && rd_cnt != '0) begin
          // next kind found: start its first flash
          state_next        = ebc_pkg::S_EMIT;
          current_kind_next = chk_k;
          flashes_done_next = '0;
          if (phase == ebc_pkg::PH_SCAN) begin
            // this tick is already the first lit tick
            led_level_next = 1'b1;
            if (on_len > TW'(1)) begin
              phase_next      = ebc_pkg::PH_ON;
              ticks_left_next = on_len - TW'(1);
            end else begin
              phase_next      = ebc_pkg::PH_OFF;
              ticks_left_next = off_len;
            end
          end else begin
            phase_next      = ebc_pkg::PH_ON;
            ticks_left_next = on_len;
          end
        end else if (chk_v && rem == KW'(1)) begin
          // nothing set: stay dark
          state_next        = ebc_pkg::S_EMIT;
          current_kind_next = '0;
          flashes_done_next = '0;
          phase_next        = ebc_pkg::PH_SCAN;
          led_level_next    = 1'b0;
        end else if (chk_v) begin
          rem_next = rem - KW'(1);
        end
      end
      ebc_pkg::S_EMIT: begin
        if (emit_go) begin
          state_next = ebc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ebc_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ebc_pkg::S_IDLE;
      phase        <= ebc_pkg::PH_SCAN;
      current_kind <= '0;
      flashes_done <= '0;
      ticks_left   <= '0;
      led_level    <= 1'b0;
      chk_v        <= 1'b0;
      rem          <= '0;
      scan_k       <= KW'(1);
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      current_kind <= current_kind_next;
      flashes_done <= flashes_done_next;
      ticks_left   <= ticks_left_next;
      led_level    <= led_level_next;
      chk_v        <= chk_v_next;
      rem          <= rem_next;
      scan_k       <= scan_k_next;
    end
  end

  // word capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= ebc_pkg::func_t'(func);
      kind_q <= error_kind;
    end
    res_cnt <= res_cnt_next;
    chk_k   <= scan_k;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks    <= ebc_pkg::ON_TICKS_RST;
      off_ticks   <= ebc_pkg::OFF_TICKS_RST;
      gap_ticks   <= ebc_pkg::GAP_TICKS_RST;
      count_limit <= ebc_pkg::COUNT_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ebc_pkg::REG_ON_TICKS:    on_ticks    <= cfg_data;
        ebc_pkg::REG_OFF_TICKS:   off_ticks   <= cfg_data;
        ebc_pkg::REG_GAP_TICKS:   gap_ticks   <= cfg_data;
        ebc_pkg::REG_COUNT_LIMIT: count_limit <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      led_on       <= led_level;
      showing_kind <= (phase == ebc_pkg::PH_SCAN) ? 4'd0 : cur_ext[3:0];
      kind_count   <= res_cnt;
    end
  end

`ifndef SYNTHESIS
  // a code under way always belongs to a real kind
  assert property (@(posedge clk) disable iff (rst)
    (phase != ebc_pkg::PH_SCAN) |-> (current_kind != '0))
    else $error("blink phase active with no kind selected");

  // a running phase always has ticks left to count, outside a kind scan
  assert property (@(posedge clk) disable iff (rst)
    (phase != ebc_pkg::PH_SCAN && state != ebc_pkg::S_SCAN) |-> (ticks_left != '0))
    else $error("blink phase active with zero ticks left");

  // flashes stay below the kind number while flashing
  assert property (@(posedge clk) disable iff (rst)
    (phase == ebc_pkg::PH_ON || phase == ebc_pkg::PH_OFF) |-> (flashes_done < current_kind))
    else $error("flash count ran past kind number");

  // a lit LED is always part of a shown code
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_on) |-> (showing_kind != 4'd0))
    else $error("led lit with no kind shown");
`endif

endmodule

FILE: tb/error_blink_code_sequencer_test.sv
module error_blink_code_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KINDS = 16;
  localparam int SETTLE_CYCLES = KINDS + 8;
  localparam int CYCLE_LIMIT = 400_000;

  // one result word as the block reports it
  typedef struct packed {
    logic                        led;
    logic [3:0]                  kind;
    logic [ebc_pkg::COUNT_W-1:0] cnt;
  } blink_word_t;

  // tracks counters and blink timing, queues the words the block owes
  class blink_board;
    logic [ebc_pkg::TICK_W-1:0]  on_len, off_len, gap_len;
    logic [ebc_pkg::COUNT_W-1:0] limit;
    logic [ebc_pkg::COUNT_W-1:0] counts [KINDS];
    logic [3:0]                  cur_kind, flashes;
    ebc_pkg::phase_t             ph;
    logic [ebc_pkg::TICK_W-1:0]  left;
    logic                        level;
    blink_word_t                 due_results[$];
    int fails, n_checked, n_lit, n_ticks, n_sets, n_clears, n_other, n_writes;
    logic [ebc_pkg::COUNT_W-1:0] top_count;

    function new();
      on_len = 16'd80;
      off_len = 16'd320;
      gap_len = 16'd1200;
      limit = 8'd255;
      foreach (counts[i]) counts[i] = '0;
      counts[1] = 8'd1;
      cur_kind = '0;
      flashes = '0;
      ph = ebc_pkg::PH_SCAN;
      left = '0;
      level = 1'b0;
      top_count = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      n_writes++;
      case (idx)
        ebc_pkg::REG_ON_TICKS:    on_len = data;
        ebc_pkg::REG_OFF_TICKS:   off_len = data;
        ebc_pkg::REG_GAP_TICKS:   gap_len = data;
        ebc_pkg::REG_COUNT_LIMIT: limit = data[ebc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // a zero duration still lasts one tick
    function logic [ebc_pkg::TICK_W-1:0] span(logic [ebc_pkg::TICK_W-1:0] v);
      return (v == '0) ? ebc_pkg::TICK_W'(1) : v;
    endfunction

    // find the next kind with a nonzero counter, wrapping over 1..KINDS-1
    function bit start_next_kind();
      int k;
      for (int hop = 1; hop < KINDS; hop++) begin
        k = int'(cur_kind) + hop;
        if (k >= KINDS) k -= KINDS - 1;
        if (counts[k] != '0) begin
          cur_kind = 4'(k);
          flashes = '0;
          ph = ebc_pkg::PH_ON;
          left = span(on_len);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // one time tick of the flash sequence
    function void advance_tick();
      if (ph == ebc_pkg::PH_SCAN) begin
        if (!start_next_kind()) begin
          cur_kind = '0;
          level = 1'b0;
          return;
        end
      end
      level = (ph == ebc_pkg::PH_ON);
      if (left > 1) begin
        left--;
        return;
      end
      left = '0;
      case (ph)
        ebc_pkg::PH_ON: begin
          ph = ebc_pkg::PH_OFF;
          left = span(off_len);
        end
        ebc_pkg::PH_OFF: begin
          flashes++;
          if (flashes < cur_kind) begin
            ph = ebc_pkg::PH_ON;
            left = span(on_len);
          end else begin
            ph = ebc_pkg::PH_GAP;
            left = span(gap_len);
          end
        end
        default: begin
          if (!start_next_kind()) begin
            ph = ebc_pkg::PH_SCAN;
            cur_kind = '0;
            flashes = '0;
          end
        end
      endcase
    endfunction

    // accepted input word: update state and queue the word it produces
    function void note_word(ebc_pkg::func_t f, logic [3:0] k);
      blink_word_t w;
      case (f)
        ebc_pkg::FUNC_TICK: begin
          n_ticks++;
          advance_tick();
        end
        ebc_pkg::FUNC_SET: begin
          n_sets++;
          if (k < KINDS && counts[k] < limit) counts[k]++;
        end
        ebc_pkg::FUNC_CLEAR: begin
          n_clears++;
          if (k < KINDS) counts[k] = '0;
        end
        default: n_other++;
      endcase
      w.led = level;
      w.kind = (ph == ebc_pkg::PH_SCAN) ? 4'd0 : cur_kind;
      w.cnt = (k < KINDS) ? counts[k] : '0;
      if (w.cnt > top_count) top_count = w.cnt;
      due_results.push_back(w);
    endfunction

    // accepted result word against the oldest owed word
    function void check_result(logic led, logic [3:0] kind,
                               logic [ebc_pkg::COUNT_W-1:0] cnt);
      blink_word_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding");
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (led === 1'b1) n_lit++;
      if (led !== want.led) begin
        $error("led_on: expected %0d, got %0d", want.led, led);
        fails++;
      end
      if (kind !== want.kind) begin
        $error("showing_kind: expected %0d, got %0d", want.kind, kind);
        fails++;
      end
      if (cnt !== want.cnt) begin
        $error("kind_count: expected %0d, got %0d", want.cnt, cnt);
        fails++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  func = ebc_pkg::FUNC_TICK;
  logic [3:0]                  error_kind = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        led_on;
  logic [3:0]                  showing_kind;
  logic [ebc_pkg::COUNT_W-1:0] kind_count;
  logic                        cfg_wen = 1'b0;
  logic [1:0]                  cfg_index = ebc_pkg::REG_ON_TICKS;
  logic [15:0]                 cfg_data = '0;

  blink_board board = new();
  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_cycles = 0;
  int cycles = 0;

  error_blink_code_sequencer #(.KIND_COUNT(KINDS)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .error_kind(error_kind),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .led_on(led_on),
    .showing_kind(showing_kind),
    .kind_count(kind_count),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall before each word, one long hold on request
  initial begin : result_sink
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_n = $urandom_range(recv_gap_max, 0);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_result(led_on, showing_kind, kind_count);
    end
  end

  // offer one word after a random gap, return once it is taken
  task automatic send_word(ebc_pkg::func_t f, logic [3:0] k);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    error_kind <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_word(f, k);
  endtask

  // wait until every owed word is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers, block idle
  task automatic write_settings(logic [15:0] on_v, off_v, gap_v, lim_v);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{on_v, off_v, gap_v, lim_v};
    idx = '{ebc_pkg::REG_ON_TICKS, ebc_pkg::REG_OFF_TICKS, ebc_pkg::REG_GAP_TICKS,
            ebc_pkg::REG_COUNT_LIMIT};
    for (int i = 0; i < 4; i++) begin
      cfg_wen <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      board.write_reg(idx[i], vals[i]);
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic pick_idling(bit calm);
    send_gap_max = (calm || $urandom_range(3, 0) == 0) ? 0 : 9;
    recv_gap_max = (calm || $urandom_range(3, 0) == 0) ? 0 : 9;
  endtask

  // random mix of ticks, sets, clears and unused codes
  task automatic run_phase(int words, int kind_hi, int tick_pct, int set_pct,
                           int clear_pct, bit calm);
    int r;
    ebc_pkg::func_t f;
    pick_idling(calm);
    repeat (words) begin
      r = $urandom_range(99, 0);
      if (r < tick_pct) f = ebc_pkg::FUNC_TICK;
      else if (r < tick_pct + set_pct) f = ebc_pkg::FUNC_SET;
      else if (r < tick_pct + set_pct + clear_pct) f = ebc_pkg::FUNC_CLEAR;
      else f = ebc_pkg::FUNC_NONE;
      send_word(f, 4'($urandom_range(kind_hi, 0)));
    end
  endtask

  initial begin
    logic [3:0] sat_kind;
    ebc_pkg::func_t sat_f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values: heartbeat lit on the first tick, kind 0 never shown
    send_word(ebc_pkg::FUNC_SET, 4'd0);
    send_word(ebc_pkg::FUNC_SET, 4'd15);
    send_word(ebc_pkg::FUNC_NONE, 4'd15);
    send_word(ebc_pkg::FUNC_CLEAR, 4'd15);
    send_word(ebc_pkg::FUNC_CLEAR, 4'd0);
    send_word(ebc_pkg::FUNC_TICK, 4'd5);
    send_word(ebc_pkg::FUNC_TICK, 4'd10);
    send_word(ebc_pkg::FUNC_SET, 4'd1);
    send_word(ebc_pkg::FUNC_NONE, 4'd0);
    settle();

    // zero on time, limit data with junk in the upper byte
    write_settings(16'd0, 16'd1, 16'd2, 16'hff03);
    repeat (4) send_word(ebc_pkg::FUNC_SET, 4'd2);
    send_word(ebc_pkg::FUNC_CLEAR, 4'd1);
    send_word(ebc_pkg::FUNC_TICK, 4'd15);
    send_word(ebc_pkg::FUNC_SET, 4'd15);
    send_word(ebc_pkg::FUNC_CLEAR, 4'd2);
    send_word(ebc_pkg::FUNC_TICK, 4'd0);
    send_word(ebc_pkg::FUNC_NONE, 4'd2);

    // back to back, burns off the heartbeat flash still under way
    run_phase(100, 15, 75, 17, 5, 1'b1);
    settle();

    // limit below existing counters
    write_settings(16'd2, 16'd3, 16'd5, 16'd1);
    run_phase(90, 15, 70, 20, 6, 1'b0);
    settle();

    // zero durations and a zero limit
    write_settings(16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(60, 15, 80, 15, 4, 1'b0);
    settle();

    // everything cleared, few kinds: dark stretches with nothing set
    write_settings(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
                   16'($urandom_range(4, 1)), 16'($urandom_range(6, 1)));
    pick_idling(1'b0);
    for (int k = 0; k < KINDS; k++) send_word(ebc_pkg::FUNC_CLEAR, 4'(k));
    run_phase(100, 3, 70, 15, 12, 1'b0);
    settle();

    // one counter driven up with repeated sets toward the top limit
    write_settings(16'd1, 16'd2, 16'd1, 16'd255);
    pick_idling(1'b0);
    sat_kind = 4'($urandom_range(15, 1));
    repeat (260) begin
      if ($urandom_range(9, 0) == 0) sat_f = ebc_pkg::FUNC_TICK;
      else sat_f = ebc_pkg::FUNC_SET;
      send_word(sat_f, sat_kind);
    end
    settle();

    // long hold on the result side while words keep coming
    write_settings(16'($urandom_range(5, 1)), 16'($urandom_range(5, 1)),
                   16'($urandom_range(5, 1)), 16'($urandom_range(255, 1)));
    hold_cycles = 300;
    run_phase(90, 15, 70, 20, 6, 1'b0);
    settle();

    write_settings(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                   16'($urandom_range(16, 1)), 16'($urandom_range(255, 1)));
    run_phase(120, 15, 70, 20, 6, 1'b0);
    settle();

    // longest durations, full limit data
    write_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_phase(30, 15, 60, 25, 8, 1'b0);
    settle();

    $display("sent %0d words: %0d ticks, %0d sets, %0d clears, %0d unused codes",
             board.n_ticks + board.n_sets + board.n_clears + board.n_other,
             board.n_ticks, board.n_sets, board.n_clears, board.n_other);
    $display("checked %0d results (%0d lit), highest count %0d, %0d register writes",
             board.n_checked, board.n_lit, board.top_count, board.n_writes);
    if (board.fails == 0 && board.due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ebc_pkg.sv
src/ebc_ram.sv
src/ebc_store.sv
src/error_blink_code_sequencer.sv
tb/error_blink_code_sequencer_test.sv
